[rtl/core/rc_pulse_to_speed_ramp_core_defines.svh]
// Assertion macros used by the checker file.
`ifndef RC_PULSE_TO_SPEED_RAMP_CORE_DEFINES_SVH
`define RC_PULSE_TO_SPEED_RAMP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcps check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcps check failed");

`endif

[rtl/core/rcps_pkg.sv]
package rcps_pkg;

  // Field widths
  localparam int PULSE_W = 15;
  localparam int SPD_W   = 16;
  localparam int DB_W    = 12;
  localparam int PROD_W  = 2 * PULSE_W;
  localparam int CFG_IDX_W = 3;

  // Serial unit step counts and counter widths
  localparam int MUL_STEPS = PULSE_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
  localparam int DIV_STEPS_FULL = PROD_W;
  localparam int DIV_STEPS_HALF = PULSE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS_FULL + 1);

  // Pulses below this width give a zero target
  localparam logic [PULSE_W-1:0] PULSE_FLOOR = PULSE_W'(800);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MID_PULSE     = 3'd0,
    CFG_MID_DEADBAND  = 3'd1,
    CFG_TOP_LIMIT     = 3'd2,
    CFG_BOTTOM_LIMIT  = 3'd3,
    CFG_RAMP_UP_DIV   = 3'd4,
    CFG_RAMP_DOWN_DIV = 3'd5,
    CFG_REVERSE       = 3'd6,
    CFG_MIN_SPEED     = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_MUL,
    ST_DIV_LIN,
    ST_SLEW,
    ST_DIV_RAMP,
    ST_FINISH
  } state_t;

  // Divider start request: half selects a 15-bit dividend
  typedef struct packed {
    logic start;
    logic half;
  } div_cmd_t;

endpackage

[rtl/core/rcps_mul.sv]
module rcps_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rcps_pkg::PULSE_W-1:0]   mcand,
  input  logic [rcps_pkg::PULSE_W-1:0]   mplier,
  output logic [rcps_pkg::PROD_W-1:0]    product,
  output logic                           done
);
  import rcps_pkg::*;

  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [PULSE_W-1:0]   mcand_r;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [PULSE_W:0]     sum;

  // Add the multiplicand on the low multiplier bit, then shift right
  always_comb begin
    sum = {1'b0, prod_r[PROD_W-1:PULSE_W]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
    prod_nxt = prod_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      prod_nxt = {{PULSE_W{1'b0}}, mplier};
      cnt_nxt = MUL_CNT_W'(MUL_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      prod_nxt = {sum, prod_r[PULSE_W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == MUL_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (start) begin
      mcand_r <= mcand;
    end
  end

  assign product = prod_r;
  assign done = done_r;

endmodule

[rtl/core/rcps_div.sv]
module rcps_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rcps_pkg::div_cmd_t            cmd,
  input  logic [rcps_pkg::PROD_W-1:0]   dividend,
  input  logic [rcps_pkg::PULSE_W-1:0]  divisor,
  output logic [rcps_pkg::PROD_W-1:0]   quotient,
  output logic                          done
);
  import rcps_pkg::*;

  logic [PULSE_W-1:0]   rem_r, rem_nxt;
  logic [PROD_W-1:0]    dq_r, dq_nxt;
  logic [PULSE_W-1:0]   dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [PULSE_W:0]     trial;
  logic [PULSE_W:0]     diff;
  logic                 ge;

  // Restoring division: one quotient bit per cycle
  always_comb begin
    trial = {rem_r, dq_r[PROD_W-1]};
    diff = trial - {1'b0, dsr_r};
    ge = (trial >= {1'b0, dsr_r});
    rem_nxt = rem_r;
    dq_nxt = dq_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      rem_nxt = '0;
      dq_nxt = cmd.half ? {dividend[PULSE_W-1:0], {(PROD_W-PULSE_W){1'b0}}} : dividend;
      cnt_nxt = cmd.half ? DIV_CNT_W'(DIV_STEPS_HALF) : DIV_CNT_W'(DIV_STEPS_FULL);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[PULSE_W-1:0] : trial[PULSE_W-1:0];
      dq_nxt = {dq_r[PROD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r <= dq_nxt;
    if (cmd.start) begin
      dsr_r <= divisor;
    end
  end

  assign quotient = dq_r;
  assign done = done_r;

endmodule

[rtl/core/rc_pulse_to_speed_ramp_core.sv]
// One request at a time; a new request is taken only once the last result is registered.
// The work is done by the bit-serial 15-step multiplier and the shared 1-bit-per-cycle
// divider (30 steps for the linear quotient, 15 for the ramp step limit, skipped when
// the target equals the stored speed); a held result stalls the last step.
// Synchronous active-low reset loads the register defaults and clears the stored speed.
module rc_pulse_to_speed_ramp_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rcps_pkg::PULSE_W-1:0]        in_pulse_width,
  input  logic [rcps_pkg::PULSE_W-1:0]        in_max_speed,
  input  logic                                in_signal_ok,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rcps_pkg::SPD_W-1:0]   out_speed_cmd,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rcps_pkg::PULSE_W-1:0]        cfg_data
);
  import rcps_pkg::*;

  // Configuration registers
  logic [PULSE_W-1:0] mid_pulse_r;
  logic [DB_W-1:0]    mid_deadband_r;
  logic [PULSE_W-1:0] top_limit_r;
  logic [PULSE_W-1:0] bottom_limit_r;
  logic [PULSE_W-1:0] ramp_up_div_r;
  logic [PULSE_W-1:0] ramp_down_div_r;
  logic               reverse_r;
  logic [PULSE_W-1:0] min_speed_r;

  // Request and working registers
  state_t                    state_r, state_nxt;
  logic [PULSE_W-1:0]        pw_r;
  logic [PULSE_W-1:0]        maxs_r;
  logic                      ok_r;
  logic                      neg_r, neg_nxt;
  logic [PULSE_W-1:0]        den_r, den_nxt;
  logic signed [SPD_W-1:0]   target_r, target_nxt;
  logic [PULSE_W-1:0]        lim_r, lim_nxt;
  logic signed [SPD_W-1:0]   ramped_r, ramped_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SPD_W-1:0]   out_speed_cmd_r, out_speed_cmd_nxt;

  // Target classification
  logic [PULSE_W:0]          up_edge;
  logic signed [PULSE_W+1:0] down_edge;
  logic                      zero_tgt;
  logic                      above;
  logic                      below;
  logic [PULSE_W-1:0]        num_sel;
  logic [PULSE_W-1:0]        den_sel;
  logic [PULSE_W-1:0]        span_spd;

  // Serial units
  logic                      mul_start;
  logic [PROD_W-1:0]         mul_product;
  logic                      mul_done;
  div_cmd_t                  div_cmd;
  logic [PROD_W-1:0]         div_dividend;
  logic [PULSE_W-1:0]        div_divisor;
  logic [PROD_W-1:0]         div_quotient;
  logic                      div_done;

  // Slew step
  logic [PULSE_W:0]          tgt_mag;
  logic signed [SPD_W:0]     slew_diff;
  logic [SPD_W:0]            slew_abs;
  logic [SPD_W:0]            slew_step;
  logic signed [SPD_W:0]     ramped_ext;
  logic [PULSE_W-1:0]        ramp_sel;
  logic                      out_free;

  assign cfg_ready = 1'b1;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_speed_cmd = out_speed_cmd_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_pulse_r <= PULSE_W'(1500);
      mid_deadband_r <= DB_W'(30);
      top_limit_r <= PULSE_W'(1950);
      bottom_limit_r <= PULSE_W'(1050);
      ramp_up_div_r <= PULSE_W'(50);
      ramp_down_div_r <= PULSE_W'(50);
      reverse_r <= 1'b0;
      min_speed_r <= PULSE_W'(500);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MID_PULSE:     mid_pulse_r <= cfg_data;
        CFG_MID_DEADBAND:  mid_deadband_r <= cfg_data[DB_W-1:0];
        CFG_TOP_LIMIT:     top_limit_r <= cfg_data;
        CFG_BOTTOM_LIMIT:  bottom_limit_r <= cfg_data;
        CFG_RAMP_UP_DIV:   ramp_up_div_r <= cfg_data;
        CFG_RAMP_DOWN_DIV: ramp_down_div_r <= cfg_data;
        CFG_REVERSE:       reverse_r <= cfg_data[0];
        CFG_MIN_SPEED:     min_speed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify the latched pulse against floor, band and limits
  always_comb begin
    up_edge = {1'b0, mid_pulse_r} + {{(PULSE_W+1-DB_W){1'b0}}, mid_deadband_r};
    down_edge = $signed({2'b00, mid_pulse_r}) -
                $signed({{(PULSE_W+2-DB_W){1'b0}}, mid_deadband_r});
    zero_tgt = !ok_r || (maxs_r < min_speed_r) || (pw_r < PULSE_FLOOR);
    above = ({1'b0, pw_r} > up_edge);
    below = ($signed({2'b00, pw_r}) < down_edge);
    span_spd = maxs_r - min_speed_r;
    num_sel = above ? (pw_r - up_edge[PULSE_W-1:0]) : (down_edge[PULSE_W-1:0] - pw_r);
    den_sel = above ? (top_limit_r - up_edge[PULSE_W-1:0])
                    : (down_edge[PULSE_W-1:0] - bottom_limit_r);
  end

  // Slew arithmetic on the registered target
  always_comb begin
    tgt_mag = {1'b0, div_quotient[PULSE_W-1:0]} + {1'b0, min_speed_r};
    ramped_ext = {ramped_r[SPD_W-1], ramped_r};
    slew_diff = {target_r[SPD_W-1], target_r} - ramped_ext;
    slew_abs = slew_diff[SPD_W] ? SPD_W'(0) - slew_diff : slew_diff;
    slew_step = (slew_abs > {2'b00, lim_r}) ? {2'b00, lim_r} : slew_abs;
    ramp_sel = (target_r > ramped_r) ? ramp_up_div_r : ramp_down_div_r;
    out_free = !out_valid_r || out_ready;
  end

  // Sequence the request through the serial units
  always_comb begin
    state_nxt = state_r;
    neg_nxt = neg_r;
    den_nxt = den_r;
    target_nxt = target_r;
    lim_nxt = lim_r;
    ramped_nxt = ramped_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_speed_cmd_nxt = out_speed_cmd_r;
    mul_start = 1'b0;
    div_cmd = '0;
    div_dividend = mul_product;
    div_divisor = den_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CLASS;
        end
      end
      ST_CLASS: begin
        neg_nxt = !above;
        den_nxt = den_sel;
        if (zero_tgt || (!above && !below)) begin
          target_nxt = '0;
          state_nxt = ST_SLEW;
        end else if (above && (pw_r > top_limit_r)) begin
          target_nxt = $signed({1'b0, maxs_r});
          state_nxt = ST_SLEW;
        end else if (!above && (pw_r < bottom_limit_r)) begin
          target_nxt = SPD_W'(0) - $signed({1'b0, maxs_r});
          state_nxt = ST_SLEW;
        end else begin
          mul_start = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_cmd.start = 1'b1;
          state_nxt = ST_DIV_LIN;
        end
      end
      ST_DIV_LIN: begin
        if (div_done) begin
          target_nxt = neg_r ? SPD_W'(0) - $signed(tgt_mag) : $signed(tgt_mag);
          state_nxt = ST_SLEW;
        end
      end
      ST_SLEW: begin
        if (target_r == ramped_r) begin
          state_nxt = ST_FINISH;
        end else begin
          div_cmd.start = 1'b1;
          div_cmd.half = 1'b1;
          div_dividend = {{(PROD_W-PULSE_W){1'b0}}, maxs_r};
          div_divisor = (ramp_sel == '0) ? PULSE_W'(1) : ramp_sel;
          state_nxt = ST_DIV_RAMP;
        end
      end
      ST_DIV_RAMP: begin
        if (div_done) begin
          lim_nxt = (div_quotient[PULSE_W-1:0] == '0) ? PULSE_W'(1)
                                                     : div_quotient[PULSE_W-1:0];
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          if (slew_diff[SPD_W]) begin
            ramped_nxt = SPD_W'(ramped_ext - $signed(slew_step));
          end else begin
            ramped_nxt = SPD_W'(ramped_ext + $signed(slew_step));
          end
          out_valid_nxt = 1'b1;
          out_speed_cmd_nxt = reverse_r ? SPD_W'(0) - ramped_nxt : ramped_nxt;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ramped_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ramped_r <= ramped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pw_r <= in_pulse_width;
      maxs_r <= in_max_speed;
      ok_r <= in_signal_ok;
    end
    neg_r <= neg_nxt;
    den_r <= den_nxt;
    target_r <= target_nxt;
    lim_r <= lim_nxt;
    out_speed_cmd_r <= out_speed_cmd_nxt;
  end

  rcps_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (span_spd),
    .mplier  (num_sel),
    .product (mul_product),
    .done    (mul_done)
  );

  rcps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

endmodule

[rtl/core/rcps_checker.sv]
`include "rc_pulse_to_speed_ramp_core_defines.svh"

module rcps_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [rcps_pkg::SPD_W-1:0]   out_speed_cmd
);
  import rcps_pkg::*;

  // Stalled result holds its value
  `RCPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_speed_cmd))

  // Input side closes right after a request is taken
  `RCPS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // No result appears in the cycle after a request is taken
  `RCPS_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

  // Speed command stays inside the symmetric range
  `RCPS_ASSERT_NOW(a_cmd_range, clk, rst_n, out_valid, out_speed_cmd != {1'b1, {(SPD_W-1){1'b0}}})

endmodule

bind rc_pulse_to_speed_ramp_core rcps_checker u_rcps_checker (.*);

[sim/tb_rc_pulse_to_speed_ramp_core.sv]
module tb_rc_pulse_to_speed_ramp_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rcps_pkg::*;

  localparam int IDLE_LIMIT     = 4000;
  localparam int PRESSURE_AT    = 300;
  localparam int PRESSURE_HOLD  = 600;
  localparam int N_PHASES       = 10;
  localparam int PHASE_REQUESTS = 113;
  localparam int N_DIRECTED     = 18;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [PULSE_W-1:0]         in_pulse_width = '0;
  logic [PULSE_W-1:0]         in_max_speed = '0;
  logic                       in_signal_ok = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SPD_W-1:0]    out_speed_cmd;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [PULSE_W-1:0]         cfg_data = '0;

  rc_pulse_to_speed_ramp_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pulse_width(in_pulse_width),
    .in_max_speed  (in_max_speed),
    .in_signal_ok  (in_signal_ok),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_speed_cmd (out_speed_cmd),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the block's registers and stored speed
  typedef struct {
    logic [PULSE_W-1:0] mid_pulse;
    logic [DB_W-1:0]    mid_deadband;
    logic [PULSE_W-1:0] top_limit;
    logic [PULSE_W-1:0] bottom_limit;
    logic [PULSE_W-1:0] ramp_up_div;
    logic [PULSE_W-1:0] ramp_down_div;
    logic               reverse;
    logic [PULSE_W-1:0] min_speed;
  } ramp_regs_t;

  ramp_regs_t              regs = '{15'd1500, 12'd30, 15'd1950, 15'd1050,
                                    15'd50, 15'd50, 1'b0, 15'd500};
  logic signed [SPD_W-1:0] stored_speed = '0;

  logic signed [SPD_W-1:0] pending_cmds [$];
  int                      n_errors = 0;
  int                      n_results = 0;
  int                      idle_cycles = 0;
  int                      send_burst = 0;

  // Directed requests; a typed value is checked as is, the rest against the predictor
  typedef struct packed {
    logic [PULSE_W-1:0]      pw;
    logic [PULSE_W-1:0]      ms;
    logic                    ok;
    logic                    typed;
    logic signed [SPD_W-1:0] val;
  } directed_row_t;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{15'd0,     15'd0,     1'b0, 1'b1, 16'sd0},     // after reset, no signal
    '{15'd32767, 15'd32767, 1'b1, 1'b1, 16'sd655},   // full forward, first ramp step
    '{15'd32767, 15'd32767, 1'b0, 1'b1, 16'sd0},     // signal lost, ramp back down
    '{15'd1500,  15'd1000,  1'b1, 1'b1, 16'sd0},     // centre of deadband
    '{15'd799,   15'd32767, 1'b1, 1'b1, 16'sd0},     // just under the pulse floor
    '{15'd800,   15'd32767, 1'b1, 1'b1, -16'sd655},  // at the floor, full reverse
    '{15'd32767, 15'd499,   1'b1, 1'b0, 16'sd0},     // max speed under min speed
    '{15'd1700,  15'd2000,  1'b1, 1'b0, 16'sd0},
    '{15'd1530,  15'd2000,  1'b1, 1'b0, 16'sd0},     // upper band edge
    '{15'd1531,  15'd2000,  1'b1, 1'b0, 16'sd0},
    '{15'd1469,  15'd2000,  1'b1, 1'b0, 16'sd0},     // just below lower band edge
    '{15'd1050,  15'd2000,  1'b1, 1'b0, 16'sd0},     // at bottom limit
    '{15'd1950,  15'd2000,  1'b1, 1'b0, 16'sd0},     // at top limit
    '{15'd1951,  15'd500,   1'b1, 1'b0, 16'sd0},     // max equals min
    '{15'h5555,  15'h2aaa,  1'b1, 1'b0, 16'sd0},
    '{15'h2aaa,  15'h5555,  1'b1, 1'b0, 16'sd0},
    '{15'd1200,  15'd0,     1'b1, 1'b0, 16'sd0},     // zero max, step floor of one
    '{15'd1200,  15'd800,   1'b0, 1'b0, 16'sd0}
  };

  // Advance the shadow speed by one tick and return the reported command
  function automatic logic signed [SPD_W-1:0] next_speed_cmd(
      logic [PULSE_W-1:0] pw_in, logic [PULSE_W-1:0] ms_in, logic ok_in);
    int pw = pw_in;
    int ms = ms_in;
    int mins = regs.min_speed;
    int up = int'(regs.mid_pulse) + int'(regs.mid_deadband);
    int dn = int'(regs.mid_pulse) - int'(regs.mid_deadband);
    int top = regs.top_limit;
    int bot = regs.bottom_limit;
    int floor_w = PULSE_FLOOR;
    int udiv = (regs.ramp_up_div == 0) ? 1 : int'(regs.ramp_up_div);
    int ddiv = (regs.ramp_down_div == 0) ? 1 : int'(regs.ramp_down_div);
    int add_lim;
    int dec_lim;
    int cur = stored_speed;
    int tgt = 0;
    int res;
    longint q;

    add_lim = ms / udiv;
    dec_lim = ms / ddiv;
    if (add_lim < 1) add_lim = 1;
    if (dec_lim < 1) dec_lim = 1;

    // Target from pulse position
    if (ok_in && ms >= mins && pw >= floor_w) begin
      if (pw > up) begin
        if (pw > top) begin
          tgt = ms;
        end else begin
          q = (longint'(pw - up) * longint'(ms - mins)) / longint'(top - up);
          tgt = int'(q) + mins;
        end
      end else if (pw < dn) begin
        if (pw < bot) begin
          tgt = -ms;
        end else begin
          q = (longint'(dn - pw) * longint'(ms - mins)) / longint'(dn - bot);
          tgt = -(int'(q) + mins);
        end
      end
    end

    // Slew toward target
    if (tgt > cur) begin
      cur = cur + (((tgt - cur) > add_lim) ? add_lim : (tgt - cur));
    end else if (tgt < cur) begin
      cur = cur - (((cur - tgt) > dec_lim) ? dec_lim : (cur - tgt));
    end
    stored_speed = SPD_W'(cur);
    res = regs.reverse ? -cur : cur;
    return SPD_W'(res);
  endfunction

  // Offer one request after a random gap and queue its expected command
  task automatic offer(input logic [PULSE_W-1:0] pw, input logic [PULSE_W-1:0] ms,
                       input logic ok, input logic typed,
                       input logic signed [SPD_W-1:0] typed_val);
    int gap = 0;
    int r;
    logic signed [SPD_W-1:0] pred;

    if (send_burst > 0) begin
      send_burst--;
    end else begin
      r = $urandom_range(99, 0);
      if (r == 0) send_burst = 60;
      else if (r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(3, 1);
      else if (r < 97) gap = $urandom_range(12, 4);
      else gap = $urandom_range(80, 20);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pulse_width <= pw;
    in_max_speed   <= ms;
    in_signal_ok   <= ok;
    do @(posedge clk); while (!in_ready);
    pred = next_speed_cmd(pw, ms, ok);
    pending_cmds.push_back(typed ? typed_val : pred);
  endtask

  // Drop valid and wait until every command has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write one register and mirror it in the shadow copy
  task automatic write_reg(input cfg_idx_t idx, input logic [PULSE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MID_PULSE:     regs.mid_pulse     = data;
      CFG_MID_DEADBAND:  regs.mid_deadband  = data[DB_W-1:0];
      CFG_TOP_LIMIT:     regs.top_limit     = data;
      CFG_BOTTOM_LIMIT:  regs.bottom_limit  = data;
      CFG_RAMP_UP_DIV:   regs.ramp_up_div   = data;
      CFG_RAMP_DOWN_DIV: regs.ramp_down_div = data;
      CFG_REVERSE:       regs.reverse       = data[0];
      CFG_MIN_SPEED:     regs.min_speed     = data;
      default: ;
    endcase
  endtask

  // Stimulus
  initial begin
    logic [PULSE_W-1:0] set_vals [8];
    logic [PULSE_W-1:0] pw;
    logic [PULSE_W-1:0] ms;
    logic               ok;
    int mid, db, mins, lo, hi, v, r;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer(directed_rows[i].pw, directed_rows[i].ms, directed_rows[i].ok,
            directed_rows[i].typed, directed_rows[i].val);
    end

    pw = '0;
    ms = '0;
    ok = 1'b0;
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      // Order: mid, deadband, top, bottom, up div, down div, reverse, min speed
      case (p)
        0: set_vals = '{15'd1500, 15'd30, 15'd1950, 15'd1050, 15'd1, 15'd1, 15'd1, 15'd500};
        // zero span on both sides
        1: set_vals = '{15'd1500, 15'd30, 15'd1000, 15'd2000, 15'd3, 15'd7, 15'd0, 15'd0};
        // deadband wider than centre, lower edge negative
        2: set_vals = '{15'd100, 15'd4095, 15'd5000, 15'd0, 15'd4, 15'd2, 15'd1, 15'd1000};
        3: set_vals = '{15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff,
                        15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff};
        // zero divisors act as one
        4: set_vals = '{15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0};
        N_PHASES - 1: begin
          for (int i = 0; i < 8; i++) set_vals[i] = PULSE_W'($urandom_range(32767, 0));
        end
        default: begin
          mid = $urandom_range(3000, 900);
          set_vals[0] = PULSE_W'(mid);
          set_vals[1] = PULSE_W'($urandom_range(200, 0));
          set_vals[2] = PULSE_W'(mid + $urandom_range(1200, 0) - 100);
          v = mid - $urandom_range(1200, 0) + 100;
          set_vals[3] = PULSE_W'((v < 0) ? 0 : v);
          set_vals[4] = PULSE_W'($urandom_range(60, 0));
          set_vals[5] = PULSE_W'($urandom_range(60, 0));
          set_vals[6] = PULSE_W'($urandom_range(1, 0));
          set_vals[7] = PULSE_W'($urandom_range(2500, 0));
        end
      endcase
      for (int i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), set_vals[i]);
      cfg_valid <= 1'b0;

      mid  = regs.mid_pulse;
      db   = regs.mid_deadband;
      mins = regs.min_speed;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        // Hold the previous request now and then so the ramp can settle
        if ($urandom_range(9, 0) != 0) begin
          r = $urandom_range(99, 0);
          if (r < 55) begin
            lo = ((int'(regs.bottom_limit) < mid - db) ? int'(regs.bottom_limit) : mid - db) - 100;
            hi = ((int'(regs.top_limit) > mid + db) ? int'(regs.top_limit) : mid + db) + 100;
            if (lo < 0) lo = 0;
            if (hi > 32767) hi = 32767;
            if (lo > hi) lo = hi;
            v = $urandom_range(hi, lo);
          end else if (r < 70) begin
            case ($urandom_range(4, 0))
              0: v = mid - db;
              1: v = mid + db;
              2: v = regs.top_limit;
              3: v = regs.bottom_limit;
              default: v = PULSE_FLOOR;
            endcase
            v = v + $urandom_range(4, 0) - 2;
            if (v < 0) v = 0;
            if (v > 32767) v = 32767;
          end else begin
            v = $urandom_range(32767, 0);
          end
          pw = PULSE_W'(v);

          r = $urandom_range(99, 0);
          if (r < 65) begin
            hi = (mins + 4000 > 32767) ? 32767 : mins + 4000;
            ms = PULSE_W'($urandom_range(hi, mins));
          end else if (r < 85 || mins == 0) begin
            ms = PULSE_W'($urandom_range(32767, 0));
          end else begin
            ms = PULSE_W'($urandom_range(mins - 1, 0));
          end
          ok = ($urandom_range(19, 0) != 0);
        end
        offer(pw, ms, ok, 1'b0, '0);
      end
    end

    drain();
    repeat (80) @(posedge clk);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Check returned commands and drive out_ready
  always @(posedge clk) begin : speed_sink
    logic signed [SPD_W-1:0] want;
    static int hold = 0;
    static int free_run = 0;
    static bit pressure_done = 0;
    int r;

    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_cmds.size() == 0) begin
          $display("%0t: speed_cmd %0d with no request pending", $time, out_speed_cmd);
          n_errors++;
        end else begin
          want = pending_cmds.pop_front();
          if (out_speed_cmd !== want) begin
            $display("%0t: speed_cmd mismatch, expected %0d, got %0d",
                     $time, want, out_speed_cmd);
            n_errors++;
          end
        end
        n_results++;
      end

      // Long hold once so the input side backs up
      if (n_results == PRESSURE_AT && !pressure_done) begin
        pressure_done = 1;
        hold = PRESSURE_HOLD;
      end

      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (free_run > 0) begin
        out_ready <= 1'b1;
        free_run--;
      end else begin
        r = $urandom_range(199, 0);
        if (r == 0) begin
          free_run = 150;
          out_ready <= 1'b1;
        end else if (r < 130) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          hold = (r < 196) ? $urandom_range(2, 0) : $urandom_range(60, 15);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake on the input, output or configuration side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
